// ----- rtl/core/assert_macros.svh -----
// Assertion macros shared by the RTL of the sorted priority queue.
// No dependencies; define NO_ASSERTIONS to compile the checks out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS
`define SPQ_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define SPQ_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SPQ_ASSERT(label, clk, rstn, prop, msg)
`define SPQ_ASSERT_ALWAYS(label, clk, prop, msg)
`endif

`endif

// ----- rtl/core/spq_pkg.sv -----
// Types, codes and sizes for the sorted priority queue.
// No dependencies; used by spq_cell and sorted_priority_queue.
`timescale 1ns / 1ps
`default_nettype none

package spq_pkg;

    localparam int unsigned SPQ_DEPTH = 16;
    localparam int unsigned CNT_W     = $clog2(SPQ_DEPTH + 1);
    localparam int unsigned VALUE_W   = 32;
    localparam int unsigned PRIO_W    = 16;
    localparam int unsigned OP_W      = 2;
    localparam int unsigned STATUS_W  = 2;
    localparam int unsigned S_DATA_W  = 48;
    localparam int unsigned M_DATA_W  = 56;

    localparam logic [OP_W-1:0] OP_ENQ  = 2'd0;
    localparam logic [OP_W-1:0] OP_DEQ  = 2'd1;
    localparam logic [OP_W-1:0] OP_PEEK = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

    typedef logic [CNT_W-1:0] count_t;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic [PRIO_W-1:0]  prio;
    } entry_t;

    typedef struct packed {
        logic   enq;
        logic   deq;
        entry_t item;
    } shift_t;

endpackage

`default_nettype wire

// ----- rtl/core/spq_cell.sv -----
// One slot of the sorted queue chain: holds an entry and shifts with its neighbors.
// Depends on spq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module spq_cell
    import spq_pkg::*;
(
    input  wire logic   aclk,
    input  wire shift_t cmd,
    input  wire logic   occupied,
    input  wire entry_t left_entry,
    input  wire logic   left_le,
    input  wire entry_t right_entry,
    output entry_t      entry,
    output logic        le
);

    entry_t entry_reg;
    entry_t entry_next;

    assign le    = occupied && (entry_reg.prio <= cmd.item.prio);
    assign entry = entry_reg;

    always_comb begin
        entry_next = entry_reg;
        if (cmd.enq) begin
            if (!left_le) begin
                entry_next = left_entry;
            end else if (!le) begin
                entry_next = cmd.item;
            end
        end else if (cmd.deq) begin
            entry_next = right_entry;
        end
    end

    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
    end

endmodule

`default_nettype wire

// ----- rtl/core/sorted_priority_queue.sv -----
// The result of an accepted item is registered in the output register.
// Throughput: one item per cycle unless the output stalls; every cell compares
// against the new priority in parallel and shifts in the same cycle.
// Reset: clears the fill count and the output valid; cell contents are not cleared.
// Top level of the sorted priority queue; depends on spq_pkg, spq_cell and
// assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module sorted_priority_queue
    import spq_pkg::*;
(
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    // [31:0] item_value, [47:32] item_priority
    input  wire logic [S_DATA_W-1:0] s_tdata,
    // [1:0] op
    input  wire logic [OP_W-1:0]     s_tuser,
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    // [1:0] status, [33:2] front_value, [49:34] front_priority,
    // [50] is_empty, [51] is_full, [55:52] zero
    output logic [M_DATA_W-1:0]      m_tdata
);

    count_t                count_reg;
    count_t                count_next;
    logic                  m_valid_reg;
    logic [M_DATA_W-1:0]   m_data_reg;
    logic [M_DATA_W-1:0]   m_data_next;

    logic                  s_fire;
    logic                  is_empty_now;
    logic                  is_full_now;
    logic [STATUS_W-1:0]   status;
    entry_t                front;
    shift_t                cmd;

    entry_t                cell_entry [SPQ_DEPTH];
    logic   [SPQ_DEPTH-1:0] cell_le;

    assign s_tready     = !m_valid_reg || m_tready;
    assign s_fire       = s_tvalid && s_tready;
    assign is_empty_now = (count_reg == '0);
    assign is_full_now  = (count_reg == CNT_W'(SPQ_DEPTH));

    assign cmd.item.value = s_tdata[VALUE_W-1:0];
    assign cmd.item.prio  = s_tdata[VALUE_W +: PRIO_W];
    assign cmd.enq        = s_fire && (s_tuser == OP_ENQ) && !is_full_now;
    assign cmd.deq        = s_fire && (s_tuser == OP_DEQ) && !is_empty_now;

    for (genvar i = 0; i < SPQ_DEPTH; i++) begin : g_cell
        entry_t left_entry;
        logic   left_le;
        entry_t right_entry;

        if (i == 0) begin : g_head
            assign left_entry = cmd.item;
            assign left_le    = 1'b1;
        end else begin : g_body
            assign left_entry = cell_entry[i-1];
            assign left_le    = cell_le[i-1];
        end

        if (i == SPQ_DEPTH - 1) begin : g_tail
            assign right_entry = cell_entry[i];
        end else begin : g_inner
            assign right_entry = cell_entry[i+1];
        end

        spq_cell u_cell (
            .aclk        (aclk),
            .cmd         (cmd),
            .occupied    (count_reg > CNT_W'(i)),
            .left_entry  (left_entry),
            .left_le     (left_le),
            .right_entry (right_entry),
            .entry       (cell_entry[i]),
            .le          (cell_le[i])
        );
    end

    always_comb begin
        count_next = count_reg;
        status     = ST_OK;
        front      = '0;
        unique case (s_tuser)
            OP_ENQ: begin
                if (is_full_now) begin
                    status = ST_FULL;
                end else begin
                    count_next = count_reg + 1'b1;
                end
            end
            OP_DEQ: begin
                if (is_empty_now) begin
                    status = ST_EMPTY;
                end else begin
                    front      = cell_entry[0];
                    count_next = count_reg - 1'b1;
                end
            end
            OP_PEEK: begin
                if (is_empty_now) begin
                    status = ST_EMPTY;
                end else begin
                    front = cell_entry[0];
                end
            end
            default: begin
                status = ST_OK;
            end
        endcase
        m_data_next = {4'b0000,
                       (count_next == CNT_W'(SPQ_DEPTH)),
                       (count_next == '0),
                       front.prio,
                       front.value,
                       status};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (s_fire) begin
                count_reg   <= count_next;
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            m_data_reg <= m_data_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    `SPQ_ASSERT(a_count_bound, aclk, aresetn, count_reg <= CNT_W'(SPQ_DEPTH), "fill count above depth")
    `SPQ_ASSERT(a_enq_grows, aclk, aresetn, cmd.enq |=> count_reg == $past(count_reg) + 1'b1, "enqueue did not grow count")
    `SPQ_ASSERT(a_empty_flag, aclk, aresetn, m_valid_reg |-> (m_data_reg[50] == (count_reg == '0)), "empty flag disagrees with count")
    `SPQ_ASSERT(a_full_status, aclk, aresetn, (m_valid_reg && m_data_reg[1:0] == ST_FULL) |-> m_data_reg[51], "full status without full flag")

endmodule

`default_nettype wire

// ----- tb/tb_sorted_priority_queue.sv -----
// Self-checking bench for sorted_priority_queue: directed corner items, then
// random fill and drain bursts under four idle patterns. Depends on spq_pkg and the RTL.
`timescale 1ns / 1ps

module tb_sorted_priority_queue;
    import spq_pkg::*;

    localparam logic [OP_W-1:0] OP_NOP = 2'd3;
    localparam int RUN_LIMIT   = 400000;
    localparam int MAX_REPORTS = 10;

    typedef struct packed {
        logic [OP_W-1:0]    op;
        logic [PRIO_W-1:0]  prio;
        logic [VALUE_W-1:0] value;
    } request_t;

    typedef struct packed {
        logic [3:0]          pad;
        logic                full;
        logic                empty;
        logic [PRIO_W-1:0]   prio;
        logic [VALUE_W-1:0]  value;
        logic [STATUS_W-1:0] status;
    } response_t;

    logic                aclk     = 1'b0;
    logic                aresetn  = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata  = '0;
    logic [OP_W-1:0]     s_tuser  = '0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;

    sorted_priority_queue dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #5 aclk = ~aclk;

    request_t  pending_requests[$];
    response_t expected_responses[$];

    logic [VALUE_W-1:0] slot_value[SPQ_DEPTH];
    logic [PRIO_W-1:0]  slot_prio[SPQ_DEPTH];
    int fill_level = 0;
    int peak_fill  = 0;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    logic in_fire = 1'b0;
    int cycle_count = 0;
    int mismatches = 0;
    int results_checked = 0;
    int n_inserted = 0, n_rejected_full = 0, n_read_empty = 0, n_served = 0, n_full_hits = 0;

    request_t  next_req;
    response_t got_rsp;
    response_t want_rsp;

    task automatic apply_queue_op(input request_t rq, output response_t rs);
        int pos;
        int i;
        rs = '0;
        case (rq.op)
            OP_ENQ: begin
                if (fill_level == SPQ_DEPTH) begin
                    rs.status = ST_FULL;
                    n_rejected_full++;
                end else begin
                    pos = 0;
                    while (pos < fill_level && slot_prio[pos] <= rq.prio) pos++;
                    for (i = fill_level; i > pos; i--) begin
                        slot_value[i] = slot_value[i-1];
                        slot_prio[i]  = slot_prio[i-1];
                    end
                    slot_value[pos] = rq.value;
                    slot_prio[pos]  = rq.prio;
                    fill_level++;
                    n_inserted++;
                    if (fill_level == SPQ_DEPTH) n_full_hits++;
                end
            end
            OP_DEQ, OP_PEEK: begin
                if (fill_level == 0) begin
                    rs.status = ST_EMPTY;
                    n_read_empty++;
                end else begin
                    rs.value = slot_value[0];
                    rs.prio  = slot_prio[0];
                    n_served++;
                    if (rq.op == OP_DEQ) begin
                        for (i = 0; i + 1 < fill_level; i++) begin
                            slot_value[i] = slot_value[i+1];
                            slot_prio[i]  = slot_prio[i+1];
                        end
                        fill_level--;
                    end
                end
            end
            default: ;
        endcase
        rs.empty = (fill_level == 0);
        rs.full  = (fill_level == SPQ_DEPTH);
        if (fill_level > peak_fill) peak_fill = fill_level;
    endtask

    task automatic push_request(input logic [OP_W-1:0] op, input logic [VALUE_W-1:0] value,
                                input logic [PRIO_W-1:0] prio);
        request_t rq;
        rq.op    = op;
        rq.value = value;
        rq.prio  = prio;
        pending_requests.push_back(rq);
    endtask

    function automatic request_t random_request(int enq_pct, int prio_mode);
        request_t rq;
        int r;
        rq.value = $urandom;
        case (prio_mode)
            0:       rq.prio = PRIO_W'($urandom);
            1:       rq.prio = PRIO_W'($urandom_range(3));
            2:       rq.prio = $urandom_range(1) ? {PRIO_W{1'b1}} : '0;
            default: rq.prio = PRIO_W'($urandom_range(255));
        endcase
        r = $urandom_range(99);
        if (r < enq_pct)
            rq.op = OP_ENQ;
        else if (r < 96)
            rq.op = ($urandom_range(9) < 7) ? OP_DEQ : OP_PEEK;
        else
            rq.op = OP_NOP;
        return rq;
    endfunction

    // Add randomly chosen fill-heavy, drain-heavy and mixed bursts so the store hits full and empty.
    task automatic add_random_bursts(input int count);
        int added;
        int len;
        int enq_pct;
        int prio_mode;
        added = 0;
        while (added < count) begin
            len = $urandom_range(8, 40);
            case ($urandom_range(2))
                0:       enq_pct = 80;
                1:       enq_pct = 20;
                default: enq_pct = 50;
            endcase
            prio_mode = $urandom_range(3);
            repeat (len) pending_requests.push_back(random_request(enq_pct, prio_mode));
            added += len;
        end
    endtask

    task automatic run_phase(input int send_pct, input int recv_pct, input int count);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        add_random_bursts(count);
        while (pending_requests.size() != 0 || s_tvalid) @(posedge aclk);
    endtask

    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || in_fire) begin
            if (pending_requests.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                next_req = pending_requests.pop_front();
                s_tvalid <= 1'b1;
                {s_tuser, s_tdata} <= next_req;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
        m_tready <= aresetn && ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge aclk) begin
        in_fire <= aresetn && s_tvalid && s_tready;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                apply_queue_op(request_t'({s_tuser, s_tdata}), want_rsp);
                expected_responses.push_back(want_rsp);
            end
            if (m_tvalid && m_tready) begin
                results_checked++;
                got_rsp = response_t'(m_tdata);
                if (expected_responses.size() == 0) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("unexpected result %h at cycle %0d", m_tdata, cycle_count);
                end else begin
                    want_rsp = expected_responses.pop_front();
                    if (got_rsp !== want_rsp) begin
                        mismatches++;
                        if (mismatches <= MAX_REPORTS) begin
                            $display("mismatch cycle %0d (exp/got) status %0d/%0d value %h/%h",
                                     cycle_count, want_rsp.status, got_rsp.status,
                                     want_rsp.value, got_rsp.value);
                            $display("    prio %h/%h empty %b/%b full %b/%b pad %h/%h",
                                     want_rsp.prio, got_rsp.prio,
                                     want_rsp.empty, got_rsp.empty,
                                     want_rsp.full, got_rsp.full,
                                     want_rsp.pad, got_rsp.pad);
                        end
                    end
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= RUN_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("tb_sorted_priority_queue: FAIL");
            $finish;
        end
    end

    initial begin
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        push_request(OP_DEQ,  32'h1234_5678, 16'h0001);
        push_request(OP_PEEK, 32'h0, 16'h0);
        push_request(OP_NOP,  32'hFFFF_FFFF, 16'hFFFF);
        push_request(OP_ENQ,  32'h7FFF_FFFF, 16'hFFFF);
        push_request(OP_ENQ,  32'h8000_0000, 16'h0000);
        push_request(OP_ENQ,  32'hFFFF_FFFF, 16'h8000);
        push_request(OP_ENQ,  32'h0000_0000, 16'h8000);
        push_request(OP_ENQ,  32'h0000_0001, 16'h0000);
        for (int i = 0; i < SPQ_DEPTH - 5; i++)
            push_request(OP_ENQ, VALUE_W'(i + 100), PRIO_W'(i % 3));
        push_request(OP_ENQ,  32'h5A5A_A5A5, 16'h0000);
        push_request(OP_PEEK, 32'h0, 16'h0);
        push_request(OP_NOP,  32'h0, 16'h0);
        push_request(OP_DEQ,  32'h0, 16'h0);
        push_request(OP_DEQ,  32'h0, 16'h0);

        run_phase(0,  0,  175);
        run_phase(87, 0,  175);
        run_phase(0,  87, 175);
        run_phase(34, 34, 175);

        while (expected_responses.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);

        $display("checked %0d results: %0d inserts, %0d full rejects, %0d empty reads",
                 results_checked, n_inserted, n_rejected_full, n_read_empty);
        $display("served %0d fronts, store full %0d times, peak fill %0d of %0d, %0d mismatches",
                 n_served, n_full_hits, peak_fill, SPQ_DEPTH, mismatches);
        if (mismatches == 0 && expected_responses.size() == 0)
            $display("tb_sorted_priority_queue: PASS");
        else
            $display("tb_sorted_priority_queue: FAIL");
        $finish;
    end

endmodule
